FILE: design/bone_hierarchy_global_transform_defines.svh
// assertion macros for the bone hierarchy transform block
`ifndef BONE_HIERARCHY_GLOBAL_TRANSFORM_DEFINES_SVH
`define BONE_HIERARCHY_GLOBAL_TRANSFORM_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define BHGT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BHGT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/bhgt_pkg.sv
// shared types and constants for the bone hierarchy transform block
`default_nettype none

package bhgt_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BONE_W   = 6;
   localparam int unsigned PARENT_W = 7;
   localparam int unsigned COL_W    = 2;
   localparam int unsigned VEC_N    = 4;
   localparam int unsigned MAT_N    = 16;
   localparam int unsigned PROD_W   = 64;
   localparam int unsigned SUM_W    = 66;
   localparam int unsigned BONE_SPAN = 64;

   localparam logic signed [PARENT_W-1:0] ROOT_PARENT = -7'sd1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [VEC_N-1:0][WORD_W-1:0] vec_type;
   typedef logic [MAT_N-1:0][WORD_W-1:0] mat_type;

   // one column written back to the store
   typedef struct packed {
      logic              valid;
      logic [BONE_W-1:0] bone;
      logic [COL_W-1:0]  col;
      vec_type           data;
   } wr_type;

   // load enables for the multiply and sum stages
   typedef struct packed {
      logic s2_load;
      logic s3_load;
   } stage_en_type;

endpackage

`default_nettype wire

FILE: design/bhgt_req_if.sv
// request channel: one local matrix column per request
`default_nettype none

interface bhgt_req_if;
   import bhgt_pkg::*;

   logic                valid;
   logic                ready;
   logic [BONE_W-1:0]   bone_index;
   logic signed [PARENT_W-1:0] parent_index;
   logic [COL_W-1:0]    column;
   word_type            local_x;
   word_type            local_y;
   word_type            local_z;
   word_type            local_w;
   logic                last_bone;

   modport source (
      output valid, bone_index, parent_index, column,
             local_x, local_y, local_z, local_w, last_bone,
      input  ready
   );

   modport sink (
      input  valid, bone_index, parent_index, column,
             local_x, local_y, local_z, local_w, last_bone,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/bhgt_rsp_if.sv
// response channel: one global matrix column per response
`default_nettype none

interface bhgt_rsp_if;
   import bhgt_pkg::*;

   logic              valid;
   logic              ready;
   logic [BONE_W-1:0] out_bone;
   logic [COL_W-1:0]  out_column;
   word_type          global_x;
   word_type          global_y;
   word_type          global_z;
   word_type          global_w;
   logic              parent_error;
   logic              out_last;

   modport source (
      output valid, out_bone, out_column, global_x, global_y, global_z, global_w,
             parent_error, out_last,
      input  ready
   );

   modport sink (
      input  valid, out_bone, out_column, global_x, global_y, global_z, global_w,
             parent_error, out_last,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/bhgt_store.sv
// global matrix store: sixteen banks, one per matrix element, one word per bone
`default_nettype none

module bhgt_store #(
   parameter int unsigned DEPTH = 64,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   input  bhgt_pkg::wr_type  wr,
   output bhgt_pkg::mat_type rd_data
);
   import bhgt_pkg::*;

   mat_type rd_data_ff;

   for (genvar b = 0; b < MAT_N; b++) begin : g_bank
      // bank b holds column b/4, row b%4 of every bone
      logic [WORD_W-1:0] bank_mem [DEPTH];

      always_ff @(posedge clock) begin
         if (wr.valid && (wr.col == COL_W'(b / VEC_N))) begin
            bank_mem[wr.bone[ADDR_W-1:0]] <= wr.data[b % VEC_N];
         end
         rd_data_ff[b] <= bank_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/bhgt_row_dot.sv
// one row of the 4x4 product: four multipliers, sum, shift and saturate
`default_nettype none

module bhgt_row_dot #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                   clock,
   input  bhgt_pkg::stage_en_type stage_en,
   input  bhgt_pkg::vec_type      row_vec,
   input  bhgt_pkg::vec_type      local_vec,
   output bhgt_pkg::word_type     dot_out
);
   import bhgt_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_MAX =
      {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_MIN =
      {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff [VEC_N];
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  shifted;

   always_ff @(posedge clock) begin
      if (stage_en.s2_load) begin
         for (int k = 0; k < VEC_N; k++) begin
            prod_ff[k] <= $signed(row_vec[k]) * $signed(local_vec[k]);
         end
      end
      if (stage_en.s3_load) begin
         sum_ff <= sum_in;
      end
   end

   // exact sum of the four products
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < VEC_N; k++) begin
         sum_in = sum_in + SUM_W'(prod_ff[k]);
      end
   end

   // floor shift, then clamp to the signed word range
   assign shifted = sum_ff >>> FRAC_BITS;

   always_comb begin
      if (shifted > SAT_MAX) begin
         dot_out = SAT_MAX[WORD_W-1:0];
      end else if (shifted < SAT_MIN) begin
         dot_out = SAT_MIN[WORD_W-1:0];
      end else begin
         dot_out = shifted[WORD_W-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: design/bone_hierarchy_global_transform.sv
// bone hierarchy global transform: forward kinematics on 4x4 Q16.16 pose matrices
//
// req_bus carries one column of a bone's local matrix per request, with the bone
// and parent index; rsp_bus returns the matching global column, one response per
// request, in request order. Bones must arrive parent before child.
// A request passes through stage 1 (parent fetch), stage 2 (multiply) and stage 3
// (sum), then is shifted and saturated into the output register, which presents the response.
// One request is taken per cycle unless stage 1 is held. A request whose parent bone
// still sits in the multiply or sum stage waits until that column is written back;
// writes that land while it waits are forwarded in.
// The parent matrix comes from sixteen single-port-read banks, one per element,
// all read in the same cycle and written one column (four banks) per result.
// When rsp_bus is stalled the output register holds, the three inner stages
// still fill, and req_bus.ready drops once they are all full or on a parent hazard.
// Reset (synchronous) empties the pipeline; the banks are not cleared, and
// a parent column not written since reset reads stale or undefined data.
`default_nettype none
`include "bone_hierarchy_global_transform_defines.svh"

module bone_hierarchy_global_transform #(
   parameter int unsigned MAX_BONES = 64,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   bhgt_req_if.sink   req_bus,
   bhgt_rsp_if.source rsp_bus
);
   import bhgt_pkg::*;

   localparam int unsigned DEPTH  = (MAX_BONES < BONE_SPAN) ? MAX_BONES : BONE_SPAN;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic mat_type patch_mat(mat_type m, wr_type w, logic [BONE_W-1:0] paddr);
      mat_type r;
      r = m;
      if (w.valid && (w.bone == paddr)) begin
         for (int i = 0; i < VEC_N; i++) begin
            r[{w.col, COL_W'(i)}] = w.data[i];
         end
      end
      return r;
   endfunction

   // handshake and stage control
   logic o_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free, req_take, hazard;
   logic req_root, req_err;
   stage_en_type stage_en;

   // stage 1: fetched parent matrix and request fields
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_fresh_ff;
   logic [BONE_W-1:0] s1_bone_ff, s1_paddr_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_last_ff, s1_err_ff, s1_mul_ff;
   vec_type           s1_local_ff;
   mat_type           s1_mat_ff, s1_mat_in, mat_eff, rd_data;

   // stage 2: products
   logic              s2_valid_ff, s2_valid_in;
   logic [BONE_W-1:0] s2_bone_ff;
   logic [COL_W-1:0]  s2_col_ff;
   logic              s2_last_ff, s2_err_ff, s2_mul_ff;
   vec_type           s2_local_ff;

   // stage 3: sums
   logic              s3_valid_ff, s3_valid_in;
   logic [BONE_W-1:0] s3_bone_ff;
   logic [COL_W-1:0]  s3_col_ff;
   logic              s3_last_ff, s3_err_ff, s3_mul_ff;
   vec_type           s3_local_ff;

   // output register
   logic              o_valid_ff, o_valid_in;
   logic [BONE_W-1:0] out_bone_ff;
   logic [COL_W-1:0]  out_col_ff;
   vec_type           out_vec_ff;
   logic              out_err_ff, out_last_ff;

   wr_type   wr_now, wr_prev_ff;
   vec_type  row_vec [VEC_N];
   word_type dot_q [VEC_N];
   vec_type  result;

   assign o_free  = !o_valid_ff || rsp_bus.ready;
   assign s3_go   = s3_valid_ff && o_free;
   assign s3_free = !s3_valid_ff || s3_go;
   assign s2_go   = s2_valid_ff && s3_free;
   assign s2_free = !s2_valid_ff || s2_go;

   // parent column still on its way to the store
   assign hazard = s1_mul_ff &&
                   ((s2_valid_ff && (s2_bone_ff == s1_paddr_ff)) ||
                    (s3_valid_ff && (s3_bone_ff == s1_paddr_ff)));

   assign s1_go    = s1_valid_ff && !hazard && s2_free;
   assign s1_free  = !s1_valid_ff || s1_go;
   assign req_take = req_bus.valid && s1_free;
   assign req_bus.ready = s1_free;

   assign stage_en.s2_load = s1_go;
   assign stage_en.s3_load = s2_go;

   assign req_root = (req_bus.parent_index == ROOT_PARENT);
   assign req_err  = !req_root &&
                     (req_bus.parent_index[PARENT_W-1] ||
                      (req_bus.parent_index[BONE_W-1:0] >= req_bus.bone_index) ||
                      (32'(req_bus.parent_index[BONE_W-1:0]) >= MAX_BONES));

   bhgt_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .rd_addr (req_bus.parent_index[ADDR_W-1:0]),
      .wr      (wr_now),
      .rd_data (rd_data)
   );

   // fresh fetch misses the write of the accept edge; a held matrix picks up each write
   assign mat_eff   = s1_fresh_ff ? patch_mat(rd_data, wr_prev_ff, s1_paddr_ff) : s1_mat_ff;
   assign s1_mat_in = patch_mat(mat_eff, wr_now, s1_paddr_ff);

   for (genvar r = 0; r < VEC_N; r++) begin : g_row
      always_comb begin
         for (int k = 0; k < VEC_N; k++) begin
            row_vec[r][k] = mat_eff[k*VEC_N + r];
         end
      end

      bhgt_row_dot #(
         .FRAC_BITS (FRAC_BITS)
      ) u_row_dot (
         .clock     (clock),
         .stage_en  (stage_en),
         .row_vec   (row_vec[r]),
         .local_vec (s1_local_ff),
         .dot_out   (dot_q[r])
      );

      assign result[r] = s3_mul_ff ? dot_q[r] : s3_local_ff[r];
   end

   assign wr_now.valid = s3_go && (32'(s3_bone_ff) < MAX_BONES);
   assign wr_now.bone  = s3_bone_ff;
   assign wr_now.col   = s3_col_ff;
   assign wr_now.data  = result;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_go);
   assign s2_valid_in = s1_go || (s2_valid_ff && !s2_go);
   assign s3_valid_in = s2_go || (s3_valid_ff && !s3_go);
   assign o_valid_in  = s3_go || (o_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         s1_fresh_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         o_valid_ff       <= 1'b0;
         wr_prev_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         s1_fresh_ff      <= req_take;
         s2_valid_ff      <= s2_valid_in;
         s3_valid_ff      <= s3_valid_in;
         o_valid_ff       <= o_valid_in;
         wr_prev_ff       <= wr_now;
      end
   end

   always_ff @(posedge clock) begin
      s1_mat_ff       <= s1_mat_in;
      if (req_take) begin
         s1_bone_ff  <= req_bus.bone_index;
         s1_paddr_ff <= req_bus.parent_index[BONE_W-1:0];
         s1_col_ff   <= req_bus.column;
         s1_last_ff  <= req_bus.last_bone;
         s1_err_ff   <= req_err;
         s1_mul_ff   <= !req_root && !req_err;
         s1_local_ff <= {req_bus.local_w, req_bus.local_z, req_bus.local_y, req_bus.local_x};
      end
      if (s1_go) begin
         s2_bone_ff  <= s1_bone_ff;
         s2_col_ff   <= s1_col_ff;
         s2_last_ff  <= s1_last_ff;
         s2_err_ff   <= s1_err_ff;
         s2_mul_ff   <= s1_mul_ff;
         s2_local_ff <= s1_local_ff;
      end
      if (s2_go) begin
         s3_bone_ff  <= s2_bone_ff;
         s3_col_ff   <= s2_col_ff;
         s3_last_ff  <= s2_last_ff;
         s3_err_ff   <= s2_err_ff;
         s3_mul_ff   <= s2_mul_ff;
         s3_local_ff <= s2_local_ff;
      end
      if (s3_go) begin
         out_bone_ff <= s3_bone_ff;
         out_col_ff  <= s3_col_ff;
         out_vec_ff  <= result;
         out_err_ff  <= s3_err_ff;
         out_last_ff <= s3_last_ff;
      end
   end

   assign rsp_bus.valid        = o_valid_ff;
   assign rsp_bus.out_bone     = out_bone_ff;
   assign rsp_bus.out_column   = out_col_ff;
   assign rsp_bus.global_x     = out_vec_ff[0];
   assign rsp_bus.global_y     = out_vec_ff[1];
   assign rsp_bus.global_z     = out_vec_ff[2];
   assign rsp_bus.global_w     = out_vec_ff[3];
   assign rsp_bus.parent_error = out_err_ff;
   assign rsp_bus.out_last     = out_last_ff;

   `BHGT_ASSERT_NOW(a_s1_not_overrun, req_take && s1_valid_ff, s1_go, "stage 1 overwritten")
   `BHGT_ASSERT_NEXT(a_result_lands, s3_go, o_valid_ff, "result lost before output register")
   `BHGT_ASSERT_NOW(a_parent_settled, s1_go && s1_mul_ff,
      !(s2_valid_ff && (s2_bone_ff == s1_paddr_ff)) &&
      !(s3_valid_ff && (s3_bone_ff == s1_paddr_ff)), "multiply used unsettled parent")

endmodule

`default_nettype wire

FILE: dv/bhgt_global_column_check.sv
// global column predictor and response checker for the bone hierarchy transform
module bhgt_global_column_check #(
   parameter int unsigned MAX_BONES = 64,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   bhgt_req_if  req_mon,
   bhgt_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   columns_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import bhgt_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [SUM_W-1:0] SAT_LO = -66'sd2147483648;

   typedef struct packed {
      logic [BONE_W-1:0] bone;
      logic [COL_W-1:0]  col;
      vec_type           data;
      logic              parent_error;
      logic              last;
   } global_col_type;

   // predicted global pose, one column vector per bone and column
   vec_type        pose_mem [MAX_BONES][VEC_N];
   global_col_type global_cols_due[$];
   int             errors = 0;

   assign mismatch_count = errors;
   assign columns_due    = global_cols_due.size();

   // row r of the parent matrix times the local column, floored and saturated
   function automatic word_type row_dot(input int p, input int r, input vec_type lcol);
      logic signed [SUM_W-1:0] acc;
      word_type a;
      word_type b;
      int k;
      acc = '0;
      for (k = 0; k < VEC_N; k++) begin
         a = pose_mem[p][k][r];
         b = lcol[k];
         acc = acc + a * b;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > SAT_HI) return 32'sh7fffffff;
      if (acc < SAT_LO) return 32'sh80000000;
      return word_type'(acc[WORD_W-1:0]);
   endfunction

   function automatic global_col_type predict_column(input logic [BONE_W-1:0] bone,
                                                     input logic signed [PARENT_W-1:0] parent,
                                                     input logic [COL_W-1:0] col,
                                                     input vec_type lcol,
                                                     input logic last);
      global_col_type res;
      int p;
      int b;
      int r;
      p = int'(parent);
      b = int'(bone);
      res.bone = bone;
      res.col  = col;
      res.last = last;
      res.parent_error = (parent != ROOT_PARENT) &&
                         (p < 0 || p >= b || p >= int'(MAX_BONES));
      if (parent == ROOT_PARENT || res.parent_error) begin
         res.data = lcol;
      end else begin
         for (r = 0; r < VEC_N; r++) res.data[r] = row_dot(p, r, lcol);
      end
      if (b < int'(MAX_BONES)) pose_mem[b][col] = res.data;
      return res;
   endfunction

   task automatic compare_word(input string label, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h got %h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      global_col_type want;
      vec_type lcol;
      if (!reset) begin
         // compare first: a response never belongs to a request taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (global_cols_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected response bone %0d column %0d", $time,
                        rsp_mon.out_bone, rsp_mon.out_column);
            end else begin
               want = global_cols_due.pop_front();
               compare_word("out_bone", WORD_W'(want.bone), WORD_W'(rsp_mon.out_bone));
               compare_word("out_column", WORD_W'(want.col), WORD_W'(rsp_mon.out_column));
               compare_word("global_x", want.data[0], rsp_mon.global_x);
               compare_word("global_y", want.data[1], rsp_mon.global_y);
               compare_word("global_z", want.data[2], rsp_mon.global_z);
               compare_word("global_w", want.data[3], rsp_mon.global_w);
               compare_word("parent_error", WORD_W'(want.parent_error),
                            WORD_W'(rsp_mon.parent_error));
               compare_word("out_last", WORD_W'(want.last), WORD_W'(rsp_mon.out_last));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            lcol[0] = req_mon.local_x;
            lcol[1] = req_mon.local_y;
            lcol[2] = req_mon.local_z;
            lcol[3] = req_mon.local_w;
            global_cols_due = {global_cols_due, predict_column(req_mon.bone_index,
               req_mon.parent_index, req_mon.column, lcol, req_mon.last_bone)};
         end
      end
   end

endmodule

FILE: dv/tb_bone_hierarchy_global_transform.sv
// stimulus and verdict for the bone hierarchy transform block
module tb_bone_hierarchy_global_transform;
   timeunit 1ns;
   timeprecision 1ps;
   import bhgt_pkg::*;

   localparam int BONES          = 64;
   localparam int REQUEST_TARGET = 1950;
   localparam int TAIL_QUIET     = 250;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 12;
   localparam word_type W_MAX    = 32'sh7fffffff;
   localparam word_type W_MIN    = 32'sh80000000;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   columns_due;
   int   sent;
   int   quiet_cycles;
   bit   idling_on;
   logic [VEC_N-1:0] cols_written [BONES];

   bhgt_req_if req_bus ();
   bhgt_rsp_if rsp_bus ();

   bone_hierarchy_global_transform dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bhgt_global_column_check column_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .columns_due    (columns_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side back-pressure in bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_bone_hierarchy_global_transform: errors");
            $finish;
         end
      end
   end

   function automatic word_type pose_word();
      word_type picks [7];
      picks = '{32'sh00010000, 32'shffff0000, 32'sh0, 32'sh1, 32'shffffffff, W_MAX, W_MIN};
      case ($urandom_range(0, 9)) inside
         [0:3]:   return word_type'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         4:       return picks[$urandom_range(0, 6)];
         [5:6]:   return word_type'($urandom());
         default: return word_type'($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
      endcase
   endfunction

   // random fully written bone in [lo, b-1], or root when none is ready
   function automatic logic signed [PARENT_W-1:0] written_parent(input int lo, input int b);
      int cands[$];
      int i;
      for (i = lo; i < b; i++) if (cols_written[i] == '1) cands = {cands, i};
      if (cands.size() == 0) return ROOT_PARENT;
      return PARENT_W'(cands[$urandom_range(0, cands.size() - 1)]);
   endfunction

   task automatic send_column(input int bone, input logic signed [PARENT_W-1:0] parent,
                              input int col, input word_type x, input word_type y,
                              input word_type z, input word_type w, input logic last);
      idling_on = (sent < REQUEST_TARGET - TAIL_QUIET) && ((sent / 150) % 3 != 2);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.bone_index   <= BONE_W'(bone);
      req_bus.parent_index <= parent;
      req_bus.column       <= COL_W'(col);
      req_bus.local_x      <= x;
      req_bus.local_y      <= y;
      req_bus.local_z      <= z;
      req_bus.local_w      <= w;
      req_bus.last_bone    <= last;
      do @(posedge clock); while (!req_bus.ready);
      cols_written[bone][col] = 1'b1;
      sent++;
   endtask

   // one skeleton: bones in order, parents mostly earlier, columns shuffled per bone
   task automatic send_skeleton();
      int n;
      int base;
      int b;
      int k;
      int j;
      int tmp;
      int order [VEC_N];
      logic signed [PARENT_W-1:0] parent;
      n = $urandom_range(2, 12);
      base = $urandom_range(0, BONES - n);
      for (b = base; b < base + n; b++) begin
         if (b == base) begin
            parent = ROOT_PARENT;
         end else begin
            case ($urandom_range(0, 19)) inside
               [0:9]:   parent = PARENT_W'(b - 1);
               17:      parent = ROOT_PARENT;
               18:      parent = PARENT_W'(b + $urandom_range(0, BONES - 1 - b));
               19:      parent = -PARENT_W'($urandom_range(2, 64));
               default: parent = written_parent(base, b);
            endcase
         end
         order = '{0, 1, 2, 3};
         for (k = VEC_N - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
         end
         for (k = 0; k < VEC_N; k++)
            send_column(b, parent, order[k], pose_word(), pose_word(), pose_word(),
                        pose_word(), (b == base + n - 1) && (k == VEC_N - 1));
      end
   endtask

   task automatic send_noise();
      int bone;
      int p;
      logic signed [PARENT_W-1:0] parent;
      bone = $urandom_range(0, BONES - 1);
      case ($urandom_range(0, 2))
         0: parent = ROOT_PARENT;
         1: begin
            parent = PARENT_W'($urandom_range(0, 127));
            p = parent;
            // a legal parent that is not fully written would read undefined data
            if (p >= 0 && p < bone && cols_written[p] != '1) parent = ROOT_PARENT;
         end
         default: parent = written_parent(0, bone);
      endcase
      send_column(bone, parent, $urandom_range(0, 3), pose_word(), pose_word(),
                  pose_word(), pose_word(), $urandom_range(0, 15) == 0);
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.bone_index   <= '0;
      req_bus.parent_index <= '0;
      req_bus.column       <= '0;
      req_bus.local_x      <= '0;
      req_bus.local_y      <= '0;
      req_bus.local_z      <= '0;
      req_bus.local_w      <= '0;
      req_bus.last_bone    <= 1'b0;
      idling_on = 1'b1;
      sent = 0;
      quiet_cycles = 0;
      foreach (cols_written[i]) cols_written[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // root with extreme columns, then an all-minimum root sent in reverse column order
      send_column(0, ROOT_PARENT, 0, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0);
      send_column(0, ROOT_PARENT, 1, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
      send_column(0, ROOT_PARENT, 2, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0);
      send_column(0, ROOT_PARENT, 3, 0, 0, 0, 0, 1'b0);
      send_column(1, ROOT_PARENT, 3, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
      send_column(1, ROOT_PARENT, 2, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
      send_column(1, ROOT_PARENT, 1, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
      send_column(1, ROOT_PARENT, 0, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
      // sum beyond 64 bits, positive and negative saturation, floor of a negative
      send_column(2, 1, 0, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
      send_column(2, 0, 1, W_MAX, 0, W_MAX, 0, 1'b0);
      send_column(2, 0, 2, 0, W_MAX, 0, 0, 1'b0);
      send_column(2, 0, 3, -1, 0, 0, 0, 1'b0);
      send_column(3, 0, 0, W_MIN, W_MIN, 0, 0, 1'b0);
      // bad parents: equal, later, negative, and a bone that is its own parent
      send_column(3, 3, 1, pose_word(), pose_word(), pose_word(), pose_word(), 1'b0);
      send_column(3, 40, 2, pose_word(), pose_word(), pose_word(), pose_word(), 1'b0);
      send_column(4, -64, 0, pose_word(), pose_word(), pose_word(), pose_word(), 1'b0);
      send_column(4, -2, 1, pose_word(), pose_word(), pose_word(), pose_word(), 1'b0);
      send_column(0, 0, 2, pose_word(), pose_word(), pose_word(), pose_word(), 1'b0);
      send_column(63, ROOT_PARENT, 0, pose_word(), pose_word(), pose_word(), pose_word(), 1'b0);
      send_column(63, ROOT_PARENT, 1, pose_word(), pose_word(), pose_word(), pose_word(), 1'b0);
      send_column(63, ROOT_PARENT, 2, pose_word(), pose_word(), pose_word(), pose_word(), 1'b0);
      send_column(63, ROOT_PARENT, 3, pose_word(), pose_word(), pose_word(), pose_word(), 1'b1);
      send_column(63, 63, 0, pose_word(), pose_word(), pose_word(), pose_word(), 1'b0);
      send_column(10, 2, 1, pose_word(), pose_word(), pose_word(), pose_word(), 1'b1);

      while (sent < REQUEST_TARGET) begin
         if ($urandom_range(0, 4) != 0) send_skeleton();
         else repeat ($urandom_range(1, 6)) send_noise();
      end
      req_bus.valid <= 1'b0;

      while (columns_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_bone_hierarchy_global_transform: clean");
      end else begin
         $display("tb_bone_hierarchy_global_transform: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/bhgt_pkg.sv
design/bhgt_req_if.sv
design/bhgt_rsp_if.sv
design/bhgt_store.sv
design/bhgt_row_dot.sv
design/bone_hierarchy_global_transform.sv
dv/bhgt_global_column_check.sv
dv/tb_bone_hierarchy_global_transform.sv
